[hw/rtl/cfa_pkg.sv]
// ----------------------------------------------------------------------------
// cfa_pkg
// shared types and codes for the contiguous fit allocator
// ----------------------------------------------------------------------------
package cfa_pkg;

  localparam logic [1:0] OP_FIRST   = 2'd0;
  localparam logic [1:0] OP_BEST    = 2'd1;
  localparam logic [1:0] OP_WORST   = 2'd2;
  localparam logic [1:0] OP_RESERVE = 2'd3;

  localparam int START_BITS  = 10;
  localparam int LENGTH_BITS = 11;
  localparam int SIZE_BITS   = 11;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_SETUP,
    ST_MARK,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic check;
    logic scan_step;
    logic mark_init;
    logic mark_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic reject;
    logic reserve;
    logic scan_done;
    logic found;
    logic mark_last;
  } sts_t;

endpackage

[hw/rtl/cfa_ctrl.sv]
// ----------------------------------------------------------------------------
// cfa_ctrl
// sequencer: map clearing, request check, scan, marking and result hand-off
// ----------------------------------------------------------------------------
module cfa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output cfa_pkg::cmd_t cmd,
  input  cfa_pkg::sts_t sts
);

  cfa_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfa_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      cfa_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) state_nxt = cfa_pkg::ST_IDLE;
      end
      cfa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = cfa_pkg::ST_CHECK;
        end
      end
      cfa_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        if (sts.reject)       state_nxt = cfa_pkg::ST_RESULT;
        else if (sts.reserve) state_nxt = cfa_pkg::ST_SETUP;
        else                  state_nxt = cfa_pkg::ST_SCAN;
      end
      cfa_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = sts.found ? cfa_pkg::ST_SETUP : cfa_pkg::ST_RESULT;
        end
      end
      cfa_pkg::ST_SETUP: begin
        cmd.mark_init = 1'b1;
        state_nxt     = cfa_pkg::ST_MARK;
      end
      cfa_pkg::ST_MARK: begin
        cmd.mark_step = 1'b1;
        if (sts.mark_last) state_nxt = cfa_pkg::ST_RESULT;
      end
      cfa_pkg::ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = cfa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cfa_pkg::ST_CLEAR;
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || cmd.out_load;
  assign out_valid     = out_valid_r;

endmodule

[hw/rtl/cfa_datapath.sv]
// ----------------------------------------------------------------------------
// cfa_datapath
// owner map memory, run tracking scan, marking pointer and result register
// ----------------------------------------------------------------------------
module cfa_datapath #(
  parameter int MAP_UNITS  = 1024,
  parameter int OWNER_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cfa_pkg::cmd_t                    cmd,
  output cfa_pkg::sts_t                    sts,
  input  logic [1:0]                       in_opcode,
  input  logic [cfa_pkg::SIZE_BITS-1:0]    in_alloc_size,
  input  logic [7:0]                       in_owner_id,
  input  logic [cfa_pkg::START_BITS-1:0]   in_start_address,
  output logic                             out_found,
  output logic [cfa_pkg::START_BITS-1:0]   out_block_start,
  output logic [cfa_pkg::LENGTH_BITS-1:0]  out_block_length
);

  localparam int AW = $clog2(MAP_UNITS);
  localparam int CW = $clog2(MAP_UNITS + 1);
  localparam int SW = (CW > cfa_pkg::SIZE_BITS) ? CW : cfa_pkg::SIZE_BITS;

  logic [OWNER_BITS-1:0] mem [MAP_UNITS];

  logic [1:0]                     op_r;
  logic [SW-1:0]                  size_r;
  logic [OWNER_BITS-1:0]          who_r;
  logic [cfa_pkg::START_BITS-1:0] first_r;

  logic [AW-1:0]         clr_r;
  logic [CW-1:0]         rd_r, rd_nxt;
  logic                  issued_r, issued_nxt;
  logic                  pv_r, pv_nxt;
  logic                  edge_r, edge_nxt;
  logic [CW-1:0]         pidx_r, pidx_nxt;
  logic [OWNER_BITS-1:0] rdata_r;
  logic [CW-1:0]         run_r, run_nxt;
  logic                  found_r, found_nxt;
  logic                  done_r, done_nxt;
  logic [AW-1:0]         where_r, where_nxt;
  logic [SW-1:0]         len_r, len_nxt;
  logic [AW-1:0]         ptr_r;
  logic [SW-1:0]         rem_r;

  logic                  out_found_r;
  logic [cfa_pkg::START_BITS-1:0]  out_start_r;
  logic [cfa_pkg::LENGTH_BITS-1:0] out_len_r;

  logic [39:0]           owner_ext;
  logic [31:0]           first_ext, where_ext, len_ext;
  logic                  is_reserve, reject, free_unit, proc, better;
  logic [SW-1:0]         room, rsv_len, run_s, run_inc_s;
  logic [CW-1:0]         run_inc, run_start;
  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [OWNER_BITS-1:0] wdata;

  assign owner_ext  = 40'(in_owner_id);
  assign first_ext  = 32'(first_r);
  assign is_reserve = (op_r == cfa_pkg::OP_RESERVE);
  assign room       = SW'(MAP_UNITS) - SW'(first_r);
  assign rsv_len    = (size_r < room) ? size_r : room;
  assign reject     = (who_r == '0) || (size_r == '0) ||
                      (is_reserve ? (first_ext >= 32'(MAP_UNITS))
                                  : (size_r > SW'(MAP_UNITS)));

  // memory: one write port shared by clearing and marking, one read port
  assign we    = cmd.clear_step || cmd.mark_step;
  assign waddr = cmd.clear_step ? clr_r : ptr_r;
  assign wdata = cmd.clear_step ? '0 : who_r;
  assign raddr = rd_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  // run tracking
  assign free_unit = !edge_r && (rdata_r == '0);
  assign run_inc   = run_r + CW'(1);
  assign run_inc_s = SW'(run_inc);
  assign run_s     = SW'(run_r);
  assign run_start = pidx_r - run_r;
  assign proc      = cmd.scan_step && pv_r && !done_r;
  assign better    = !found_r || ((op_r == cfa_pkg::OP_WORST) ? (run_s > len_r)
                                                              : (run_s < len_r));

  always_comb begin
    rd_nxt     = rd_r;
    issued_nxt = issued_r;
    pv_nxt     = pv_r;
    edge_nxt   = edge_r;
    pidx_nxt   = pidx_r;
    run_nxt    = run_r;
    found_nxt  = found_r;
    done_nxt   = done_r;
    where_nxt  = where_r;
    len_nxt    = len_r;
    if (cmd.check) begin
      rd_nxt     = '0;
      issued_nxt = 1'b0;
      pv_nxt     = 1'b0;
      run_nxt    = '0;
      done_nxt   = 1'b0;
      found_nxt  = is_reserve && !reject;
      where_nxt  = first_ext[AW-1:0];
      len_nxt    = rsv_len;
    end else if (cmd.scan_step) begin
      // issue side: one unit a cycle, then the map-end marker
      if (!issued_r) begin
        pv_nxt   = 1'b1;
        pidx_nxt = rd_r;
        if (rd_r == CW'(MAP_UNITS)) begin
          edge_nxt   = 1'b1;
          issued_nxt = 1'b1;
        end else begin
          edge_nxt = 1'b0;
          rd_nxt   = rd_r + CW'(1);
        end
      end else begin
        pv_nxt = 1'b0;
      end
      // evaluate side
      if (proc) begin
        if (op_r == cfa_pkg::OP_FIRST) begin
          if (edge_r) begin
            done_nxt = 1'b1;
          end else if (free_unit) begin
            if (run_inc_s == size_r) begin
              found_nxt = 1'b1;
              done_nxt  = 1'b1;
              where_nxt = run_start[AW-1:0];
              len_nxt   = size_r;
            end else begin
              run_nxt = run_inc;
            end
          end else begin
            run_nxt = '0;
          end
        end else begin
          if (free_unit) begin
            run_nxt = run_inc;
          end else begin
            if ((run_s >= size_r) && (run_r != '0) && better) begin
              found_nxt = 1'b1;
              where_nxt = run_start[AW-1:0];
              len_nxt   = run_s;
            end
            run_nxt = '0;
            if (edge_r) done_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r    <= '0;
      issued_r <= 1'b0;
      pv_r     <= 1'b0;
      found_r  <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      if (cmd.clear_step) clr_r <= clr_r + AW'(1);
      issued_r <= issued_nxt;
      pv_r     <= pv_nxt;
      found_r  <= found_nxt;
      done_r   <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_r    <= rd_nxt;
    edge_r  <= edge_nxt;
    pidx_r  <= pidx_nxt;
    run_r   <= run_nxt;
    where_r <= where_nxt;
    len_r   <= len_nxt;
    if (cmd.load) begin
      op_r    <= in_opcode;
      size_r  <= SW'(in_alloc_size);
      who_r   <= owner_ext[OWNER_BITS-1:0];
      first_r <= in_start_address;
    end
    if (cmd.mark_init) begin
      ptr_r <= where_r;
      rem_r <= is_reserve ? len_r : size_r;
    end else if (cmd.mark_step) begin
      ptr_r <= ptr_r + AW'(1);
      rem_r <= rem_r - SW'(1);
    end
    if (cmd.out_load) begin
      out_found_r <= found_r;
      out_start_r <= found_r ? where_ext[cfa_pkg::START_BITS-1:0] : '0;
      out_len_r   <= found_r ? len_ext[cfa_pkg::LENGTH_BITS-1:0] : '0;
    end
  end

  assign where_ext = 32'(where_r);
  assign len_ext   = 32'(len_r);

  assign sts.clear_last = (clr_r == AW'(MAP_UNITS - 1));
  assign sts.reject     = reject;
  assign sts.reserve    = is_reserve;
  assign sts.scan_done  = done_r;
  assign sts.found      = found_r;
  assign sts.mark_last  = (rem_r == SW'(1));

  assign out_found        = out_found_r;
  assign out_block_start  = out_start_r;
  assign out_block_length = out_len_r;

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear_step, cmd.check, cmd.scan_step, cmd.mark_step}))
    else $error("conflicting datapath commands");

  a_mark_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mark_step |-> (rem_r != '0))
    else $error("marking with no units left");

  a_edge_index: assert property (@(posedge clk) disable iff (!rst_n)
    (pv_r && edge_r) |-> (pidx_r == CW'(MAP_UNITS)))
    else $error("map-end marker at wrong index");

  a_fit_len: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_step && done_r && found_r) |-> (len_r >= size_r))
    else $error("chosen run shorter than request");

endmodule

[hw/rtl/contiguous_fit_allocator.sv]
// ----------------------------------------------------------------------------
// contiguous_fit_allocator
// owner map with first, best and worst fit allocation and region reserve
// ----------------------------------------------------------------------------
// in_* beat: opcode, alloc_size, owner_id, start_address (valid/ready).
// out_* beat: found, block_start, block_length, one per request.
// after reset the owner map is swept to zero, one unit a cycle, and
// in_ready stays low during the sweep.
// one request is worked at a time: a request check, then for a fit opcode a
// scan of the map through the single memory read port, one unit a cycle
// (first fit stops at the first hit), then a setup step and one write per
// marked unit on the write port, then a load of the result register.
// rejected requests skip scan and marking and go straight from the check
// to the result load.
// the result register holds its beat while out_ready is low; a finished
// request waits for the register to drain before the next beat is taken.
// ----------------------------------------------------------------------------
module contiguous_fit_allocator #(
  parameter int MAP_UNITS  = 1024,
  parameter int OWNER_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_opcode,
  input  logic [cfa_pkg::SIZE_BITS-1:0]   in_alloc_size,
  input  logic [7:0]                      in_owner_id,
  input  logic [cfa_pkg::START_BITS-1:0]  in_start_address,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_found,
  output logic [cfa_pkg::START_BITS-1:0]  out_block_start,
  output logic [cfa_pkg::LENGTH_BITS-1:0] out_block_length
);

  cfa_pkg::cmd_t cmd;
  cfa_pkg::sts_t sts;

  cfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  cfa_datapath #(
    .MAP_UNITS  (MAP_UNITS),
    .OWNER_BITS (OWNER_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_opcode),
    .in_alloc_size    (in_alloc_size),
    .in_owner_id      (in_owner_id),
    .in_start_address (in_start_address),
    .out_found        (out_found),
    .out_block_start  (out_block_start),
    .out_block_length (out_block_length)
  );

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the contiguous fit allocator against an owner map kept in the bench.
// each request beat updates the bench map and queues the grant that the
// first, best or worst fit scan or the reserve should report; every grant
// beat from the block is checked against the oldest queued grant. a directed
// set covers the map edges, clipping and the rejected cases, then random
// requests of mostly small sizes run under several idling phases and one
// long output hold-off.
// ----------------------------------------------------------------------------
module tb;

  localparam int MAP_UNITS   = 1024;
  localparam int OWNER_BITS  = 8;
  localparam int AW          = $clog2(MAP_UNITS);
  localparam int DRAIN_LIMIT = 200000;
  localparam int SETTLE      = 2 * MAP_UNITS + 16;

  typedef logic [cfa_pkg::SIZE_BITS-1:0]  size_t;
  typedef logic [cfa_pkg::START_BITS-1:0] start_t;

  typedef struct packed {
    logic                            found;
    logic [cfa_pkg::START_BITS-1:0]  start;
    logic [cfa_pkg::LENGTH_BITS-1:0] length;
  } grant_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [1:0]                      in_opcode = cfa_pkg::OP_FIRST;
  logic [cfa_pkg::SIZE_BITS-1:0]   in_alloc_size = '0;
  logic [7:0]                      in_owner_id = '0;
  logic [cfa_pkg::START_BITS-1:0]  in_start_address = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b1;
  logic                            out_found;
  logic [cfa_pkg::START_BITS-1:0]  out_block_start;
  logic [cfa_pkg::LENGTH_BITS-1:0] out_block_length;

  logic [OWNER_BITS-1:0] unit_owner [MAP_UNITS];
  grant_t                expected_grants [$];
  int                    fail_count = 0;
  int                    send_idle_pct = 0;
  int                    recv_stall_pct = 0;
  int                    hold_cycles = 0;

  contiguous_fit_allocator #(
    .MAP_UNITS (MAP_UNITS),
    .OWNER_BITS(OWNER_BITS)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_alloc_size   (in_alloc_size),
    .in_owner_id     (in_owner_id),
    .in_start_address(in_start_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_block_start (out_block_start),
    .out_block_length(out_block_length)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    for (int i = 0; i < MAP_UNITS; i++) unit_owner[i[AW-1:0]] = '0;
  end

  task automatic predict_allocation(input logic [1:0] op, input size_t size,
                                    input logic [7:0] who_in,
                                    input start_t first);
    int unsigned           sz, fst, where, len, run, count, pos;
    bit                    ok, have, free_unit, better;
    logic [OWNER_BITS-1:0] who;
    grant_t                g;
    who = who_in[OWNER_BITS-1:0];
    sz = 32'(size);
    fst = 32'(first);
    where = 0;
    len = 0;
    run = 0;
    ok = 1'b0;
    have = 1'b0;
    if (who != '0 && sz != 0) begin
      if (op == cfa_pkg::OP_RESERVE) begin
        if (fst < MAP_UNITS) begin
          len = (sz < MAP_UNITS - fst) ? sz : MAP_UNITS - fst;
          where = fst;
          ok = 1'b1;
        end
      end else if (sz <= MAP_UNITS) begin
        if (op == cfa_pkg::OP_FIRST) begin
          len = sz;
          for (int unsigned i = 0; i < MAP_UNITS && !ok; i++) begin
            if (unit_owner[i[AW-1:0]] == '0) begin
              run++;
              if (run == sz) begin
                where = i + 1 - run;
                ok = 1'b1;
              end
            end else begin
              run = 0;
            end
          end
        end else begin
          for (int unsigned i = 0; i <= MAP_UNITS; i++) begin
            free_unit = 1'b0;
            if (i < MAP_UNITS) free_unit = (unit_owner[i[AW-1:0]] == '0);
            if (free_unit) begin
              run++;
            end else begin
              if (run >= sz && run > 0) begin
                better = !have || ((op == cfa_pkg::OP_WORST) ? run > len : run < len);
                if (better) begin
                  have = 1'b1;
                  len = run;
                  where = i - run;
                end
              end
              run = 0;
            end
          end
          ok = have;
        end
      end
    end
    if (ok) begin
      count = (op == cfa_pkg::OP_RESERVE) ? len : sz;
      for (int unsigned k = 0; k < count && where + k < MAP_UNITS; k++) begin
        pos = where + k;
        unit_owner[pos[AW-1:0]] = who;
      end
    end else begin
      where = 0;
      len = 0;
    end
    g.found = ok;
    g.start = where[cfa_pkg::START_BITS-1:0];
    g.length = len[cfa_pkg::LENGTH_BITS-1:0];
    expected_grants.push_back(g);
  endtask

  task automatic offer_request(input logic [1:0] op, input size_t size,
                               input logic [7:0] who, input start_t first);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_alloc_size <= size;
    in_owner_id <= who;
    in_start_address <= first;
    do @(posedge clk); while (!in_ready);
    predict_allocation(op, size, who, first);
  endtask

  task automatic drain_grants();
    int guard;
    @(negedge clk);
    in_valid <= 1'b0;
    guard = 0;
    while (expected_grants.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
  endtask

  function automatic size_t pick_size();
    int p;
    p = $urandom_range(99);
    if (p < 85) return size_t'($urandom_range(1, 3));
    if (p < 98) return size_t'($urandom_range(4, 16));
    return size_t'($urandom_range(17, 64));
  endfunction

  task automatic offer_random_request();
    logic [1:0] op;
    size_t      size;
    logic [7:0] who;
    start_t     first;
    int         noise;
    op = 2'($urandom_range(3));
    size = pick_size();
    who = 8'($urandom_range(1, 255));
    first = start_t'($urandom_range(MAP_UNITS - 1));
    noise = $urandom_range(199);
    // occasional zero size, oversize or zero owner beats
    if (noise < 3) size = '0;
    else if (noise < 5) size = size_t'($urandom_range(MAP_UNITS + 1, 2047));
    else if (noise < 8) who = '0;
    offer_request(op, size, who, first);
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // empty map: one run spanning the whole map
    offer_request(cfa_pkg::OP_BEST, 11'd1, 8'd1, 10'd0);
    // tail run ends at the map edge
    offer_request(cfa_pkg::OP_WORST, 11'd5, 8'd2, 10'd77);
    offer_request(cfa_pkg::OP_FIRST, 11'd3, 8'd3, 10'd1023);
    // reserve clipped at the last unit
    offer_request(cfa_pkg::OP_RESERVE, 11'd100, 8'd255, 10'd1020);
    offer_request(cfa_pkg::OP_RESERVE, 11'd2047, 8'h80, 10'd1000);
    // rejected beats, then full-map sizes that find no fit
    offer_request(cfa_pkg::OP_FIRST, 11'd4, 8'd0, 10'd0);
    offer_request(cfa_pkg::OP_RESERVE, 11'd4, 8'd0, 10'd10);
    offer_request(cfa_pkg::OP_BEST, 11'd0, 8'd5, 10'd0);
    offer_request(cfa_pkg::OP_RESERVE, 11'd0, 8'd5, 10'd300);
    offer_request(cfa_pkg::OP_FIRST, 11'd1025, 8'd6, 10'd0);
    offer_request(cfa_pkg::OP_WORST, 11'd2047, 8'd6, 10'd0);
    offer_request(cfa_pkg::OP_FIRST, 11'd1024, 8'd6, 10'd0);
    offer_request(cfa_pkg::OP_BEST, 11'd1024, 8'd6, 10'd0);
    // split the free space into holes of different lengths
    offer_request(cfa_pkg::OP_RESERVE, 11'd10, 8'd7, 10'd500);
    offer_request(cfa_pkg::OP_RESERVE, 11'd1, 8'd8, 10'd200);
    offer_request(cfa_pkg::OP_BEST, 11'd3, 8'd9, 10'd0);
    offer_request(cfa_pkg::OP_WORST, 11'd3, 8'd10, 10'd0);
    offer_request(cfa_pkg::OP_RESERVE, 11'd1, 8'd11, 10'd0);
    offer_request(cfa_pkg::OP_RESERVE, 11'd1, 8'h55, 10'd1023);
    // large requests, where a no fit leaves the map alone, then small fits
    offer_request(cfa_pkg::OP_FIRST, 11'd600, 8'd12, 10'd0);
    offer_request(cfa_pkg::OP_WORST, 11'd400, 8'hAA, 10'd0);
    offer_request(cfa_pkg::OP_BEST, 11'd512, 8'd13, 10'd0);
    offer_request(cfa_pkg::OP_FIRST, 11'd40, 8'd14, 10'd0);
    offer_request(cfa_pkg::OP_BEST, 11'd1, 8'd15, 10'd0);
    drain_grants();
  endtask

  task automatic run_random_phase(input int items, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int n = 0; n < items; n++) offer_random_request();
    drain_grants();
  endtask

  task automatic test_free_running();
    run_random_phase(63, 0, 0);
  endtask

  task automatic test_sender_gaps();
    run_random_phase(63, 45, 0);
  endtask

  task automatic test_receiver_stalls();
    run_random_phase(63, 0, 45);
  endtask

  task automatic test_mixed_idling();
    run_random_phase(63, 7, 7);
  endtask

  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_cycles = 6000;
    for (int n = 0; n < 14; n++) begin
      if (n % 2 == 0)
        offer_request(cfa_pkg::OP_RESERVE, pick_size(), 8'($urandom_range(1, 255)),
                      start_t'($urandom_range(MAP_UNITS - 1)));
      else
        offer_request(cfa_pkg::OP_FIRST, pick_size(), 8'($urandom_range(1, 255)), '0);
    end
    drain_grants();
  endtask

  // output ready, with the hold-off counted down here
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_grants.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected grant beat: found %0d start %0d length %0d",
                   out_found, out_block_start, out_block_length);
      end else begin
        want = expected_grants.pop_front();
        if (out_found !== want.found || out_block_start !== want.start ||
            out_block_length !== want.length) begin
          fail_count++;
          if (fail_count <= 10)
            $display("grant mismatch: expected found %0d start %0d length %0d, got %0d %0d %0d",
                     want.found, want.start, want.length,
                     out_found, out_block_start, out_block_length);
        end
      end
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_free_running();
    test_sender_gaps();
    test_output_hold_off();
    test_receiver_stalls();
    test_mixed_idling();
    drain_grants();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && expected_grants.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[contiguous_fit_allocator.f]
hw/rtl/cfa_pkg.sv
hw/rtl/cfa_ctrl.sv
hw/rtl/cfa_datapath.sv
hw/rtl/contiguous_fit_allocator.sv
test/tb.sv
